/* rtl/order_statistic_set_top_defines.svh */
// Assertion helpers for the sorted-set block
`ifndef ORDER_STATISTIC_SET_TOP_DEFINES_SVH
`define ORDER_STATISTIC_SET_TOP_DEFINES_SVH

// Check an implication on every clock edge outside reset
`define OSS_ASSERT_IMP(label, clk, rst, lhs, rhs) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |-> (rhs)) \
      else $error("check failed");

// Check an implication in the following cycle
`define OSS_ASSERT_NEXT(label, clk, rst, lhs, rhs) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |=> (rhs)) \
      else $error("check failed");

`endif

/* rtl/oss_pkg.sv */
package oss_pkg;
   localparam int unsigned DefaultCapacity = 1024;
   localparam int unsigned ValueWidth = 32;

   typedef enum logic [1:0] {
      OP_INSERT = 2'd0,
      OP_DELETE = 2'd1,
      OP_KTH    = 2'd2,
      OP_COUNT  = 2'd3
   } opcode_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SRCH_RD,
      ST_SRCH_CMP,
      ST_DECIDE,
      ST_MOVE_RD,
      ST_MOVE_WR,
      ST_PLACE,
      ST_KTH_RD,
      ST_KTH_DATA,
      ST_RESPOND
   } state_type;
endpackage

/* rtl/oss_channel_if.sv */
interface oss_channel_if #(parameter int unsigned Width = 32);
   logic             valid;
   logic             ready;
   logic [Width-1:0] payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

/* rtl/oss_ram.sv */
module oss_ram #(
   parameter int unsigned Width = 32,
   parameter int unsigned Depth = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);
   logic [Width-1:0] mem [Depth];
   logic [Width-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

/* rtl/order_statistic_set_top.sv */
// Channel  | Direction | Payload
// req_     | in        | opcode[1:0], operand_value[31:0] signed
// rsp_     | out       | answer[31:0] signed, invalid
// One word is handled at a time by a sequencer around one sorted RAM.
// Search: binary search, each probe a read state then a compare state.
// Insert and delete then shift the tail one entry per read and write state pair (RAM port bound).
// Kth passes KTH_RD, KTH_DATA and RESPOND; count takes the search plus DECIDE and RESPOND.
// Reset is synchronous and clears only the count and control; no clearing pass.
// A result held in the output register stalls the next word's reply only.
module order_statistic_set_top
   import oss_pkg::*;
#(
   parameter int unsigned Capacity = DefaultCapacity
) (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_ready,
   input  logic [1:0] req_opcode,
   input  logic signed [31:0] req_operand_value,
   output logic rsp_valid,
   input  logic rsp_ready,
   output logic signed [31:0] rsp_answer,
   output logic rsp_invalid
);
`include "order_statistic_set_top_defines.svh"
   localparam int unsigned AW = $clog2(Capacity);
   localparam int unsigned CW = $clog2(Capacity + 1);

   oss_channel_if #(.Width(34)) req_ch ();
   oss_channel_if #(.Width(33)) rsp_ch ();
   assign req_ch.valid = req_valid;
   assign req_ch.payload = {req_opcode, req_operand_value};
   assign req_ready = req_ch.ready;
   assign rsp_valid = rsp_ch.valid;
   assign rsp_ch.ready = rsp_ready;
   assign rsp_answer = rsp_ch.payload[31:0];
   assign rsp_invalid = rsp_ch.payload[32];

   state_type state_ff, state_in;
   opcode_type op_ff;
   logic signed [31:0] x_ff;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [CW-1:0] lo_ff, lo_in, hi_ff, hi_in, mid;
   logic [CW-1:0] ptr_ff, ptr_in;
   logic [31:0] mv_ff;
   logic found_ff, found_in;
   logic rv_ff, rv_in;
   logic [32:0] rp_ff, rp_in;
   logic wr_en;
   logic [AW-1:0] wr_addr, rd_addr;
   logic [31:0] wr_data, rd_data;
   logic accept;

   oss_ram #(.Width(ValueWidth), .Depth(Capacity)) u_ram (
      .clock(clock), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data),
      .rd_addr(rd_addr), .rd_data(rd_data));

   assign accept = req_ch.valid && req_ch.ready;
   assign mid = lo_ff + ((hi_ff - lo_ff) >> 1);
   assign rsp_ch.valid = rv_ff;
   assign rsp_ch.payload = rp_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (opcode_type'(req_ch.payload[33:32]) == OP_KTH) begin
                  state_in = ST_KTH_RD;
               end else begin
                  state_in = ST_SRCH_RD;
               end
            end
         end
         ST_SRCH_RD: state_in = (lo_ff < hi_ff) ? ST_SRCH_CMP : ST_DECIDE;
         ST_SRCH_CMP: state_in = ST_SRCH_RD;
         ST_DECIDE: begin
            priority if (op_ff == OP_COUNT) begin
               state_in = ST_RESPOND;
            end else if (op_ff == OP_INSERT) begin
               state_in = (found_ff || cnt_ff >= CW'(Capacity)) ? ST_IDLE :
                          ((cnt_ff > lo_ff) ? ST_MOVE_RD : ST_PLACE);
            end else begin
               state_in = !found_ff ? ST_IDLE :
                          ((lo_ff + 1'b1 < cnt_ff) ? ST_MOVE_RD : ST_PLACE);
            end
         end
         ST_MOVE_RD: state_in = ST_MOVE_WR;
         ST_MOVE_WR: begin
            if (op_ff == OP_INSERT) begin
               state_in = (ptr_ff - 1'b1 > lo_ff) ? ST_MOVE_RD : ST_PLACE;
            end else begin
               state_in = (ptr_ff + 1'b1 < cnt_ff - 1'b1) ? ST_MOVE_RD : ST_PLACE;
            end
         end
         ST_PLACE: state_in = ST_IDLE;
         ST_KTH_RD: state_in = ST_KTH_DATA;
         ST_KTH_DATA: state_in = (!rv_ff || rsp_ch.ready) ? ST_RESPOND : ST_KTH_DATA;
         ST_RESPOND: state_in = (!rv_ff || rsp_ch.ready) ? ST_IDLE : ST_RESPOND;
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs and datapath
   always_comb begin
      req_ch.ready = (state_ff == ST_IDLE);
      lo_in = lo_ff;
      hi_in = hi_ff;
      ptr_in = ptr_ff;
      found_in = found_ff;
      cnt_in = cnt_ff;
      rv_in = rv_ff && !rsp_ch.ready;
      rp_in = rp_ff;
      wr_en = 1'b0;
      wr_addr = ptr_ff[AW-1:0];
      wr_data = mv_ff;
      rd_addr = mid[AW-1:0];
      unique case (state_ff)
         ST_IDLE: begin
            lo_in = '0;
            hi_in = cnt_ff;
            found_in = 1'b0;
         end
         ST_SRCH_CMP: begin
            // probe result arrives now
            if ($signed(rd_data) < x_ff) begin
               lo_in = mid + 1'b1;
            end else begin
               hi_in = mid;
               if ($signed(rd_data) == x_ff) begin
                  found_in = 1'b1;
               end
            end
         end
         ST_DECIDE: begin
            ptr_in = (op_ff == OP_INSERT) ? cnt_ff : lo_ff;
         end
         ST_MOVE_RD: begin
            rd_addr = (op_ff == OP_INSERT) ? AW'(ptr_ff - 1'b1) : AW'(ptr_ff + 1'b1);
         end
         ST_MOVE_WR: begin
            wr_en = 1'b1;
            wr_data = rd_data;
            ptr_in = (op_ff == OP_INSERT) ? ptr_ff - 1'b1 : ptr_ff + 1'b1;
         end
         ST_PLACE: begin
            if (op_ff == OP_INSERT) begin
               wr_en = 1'b1;
               wr_addr = lo_ff[AW-1:0];
               wr_data = x_ff;
               cnt_in = cnt_ff + 1'b1;
            end else begin
               cnt_in = cnt_ff - 1'b1;
            end
         end
         ST_KTH_RD: begin
            rd_addr = AW'(x_ff - 1);
         end
         ST_KTH_DATA: begin
            // hold the rank's entry on the read port while the last reply waits
            rd_addr = AW'(x_ff - 1);
            if (!rv_ff || rsp_ch.ready) begin
               if (x_ff <= 0 || 33'(x_ff) > 33'(cnt_ff)) begin
                  rp_in = {1'b1, 32'd0};
               end else begin
                  rp_in = {1'b0, rd_data};
               end
            end
         end
         ST_RESPOND: begin
            if (!rv_ff || rsp_ch.ready) begin
               rv_in = 1'b1;
               if (op_ff == OP_COUNT) begin
                  rp_in = {1'b0, 32'(lo_ff)};
               end
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff <= '0;
         rv_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff <= cnt_in;
         rv_ff <= rv_in;
      end
      lo_ff <= lo_in;
      hi_ff <= hi_in;
      ptr_ff <= ptr_in;
      found_ff <= found_in;
      rp_ff <= rp_in;
      mv_ff <= rd_data;
      if (accept) begin
         op_ff <= opcode_type'(req_ch.payload[33:32]);
         x_ff <= $signed(req_ch.payload[31:0]);
      end
   end

   // hold the count within capacity and words stable under stall, and no write while idle
   `OSS_ASSERT_IMP(a_cnt_bound, clock, reset, 1'b1, cnt_ff <= CW'(Capacity))
   `OSS_ASSERT_NEXT(a_rsp_hold, clock, reset, rv_ff && !rsp_ready, rv_ff && $stable(rp_ff))
   `OSS_ASSERT_IMP(a_wr_idle, clock, reset, state_ff == ST_IDLE, !wr_en)
endmodule
